// ----- rtl/mmc3_chr_ram_bank_mapper_defines.svh -----
// Assertion helpers used by mmc3_chk, the checker file of the bank mapper.
// Each one samples on clk_i and is held off while rst_ni is low.
`ifndef MMC3_CHR_RAM_BANK_MAPPER_DEFINES_SVH
`define MMC3_CHR_RAM_BANK_MAPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMC3_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMC3_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/mmc3_pkg.sv -----
package mmc3_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_PRG_COUNT   = 2'd0,
    CFG_CHR_COUNT   = 2'd1,
    CFG_FOUR_SCREEN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_e;

  // CPU register decode.
  localparam logic [15:0] REG_MASK     = 16'hE001;
  localparam logic [15:0] REG_BANK_SEL = 16'h8000;
  localparam logic [15:0] REG_BANK_DAT = 16'h8001;
  localparam logic [15:0] REG_MIRROR   = 16'hA000;
  localparam logic [15:0] REG_IRQ_CNT  = 16'hC000;
  localparam logic [15:0] REG_IRQ_LAT  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DIS  = 16'hE000;
  localparam logic [15:0] REG_IRQ_EN   = 16'hE001;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [8:0] PRG_COUNT_RESET   = 9'd32;
  localparam logic [8:0] CHR_COUNT_RESET   = 9'd64;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } item_t;

  typedef struct packed {
    logic [7:0] page_number;
    logic       page_is_ram;
    logic       irq_request;
    logic       mirror_select;
  } result_t;

  typedef struct packed {
    logic [1:0] index;
    logic [8:0] value;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// ----- rtl/mmc3_if.sv -----
interface mmc3_item_if;
  logic          valid;
  logic          ready;
  mmc3_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mmc3_result_if;
  logic            valid;
  logic            ready;
  mmc3_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mmc3_cfg_if;
  logic         valid;
  logic         ready;
  mmc3_pkg::cfg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mmc3_rem_unit.sv -----
module mmc3_rem_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [7:0]            dividend_i,
  input  logic [8:0]            divisor_i,
  output logic [7:0]            remainder_o,
  output mmc3_pkg::rem_status_t status_o
);
  import mmc3_pkg::*;

  logic [7:0] rem_q, rem_d;
  logic [7:0] dvd_q;
  logic [8:0] div_q;
  logic [2:0] cnt_q;
  logic       busy_q, done_q;
  logic [8:0] trial;
  logic [8:0] step;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  // The partial remainder stays below the divisor and never exceeds the dividend, so eight bits hold it.
  always_comb begin
    trial = {rem_q, dvd_q[7]};
    step  = (trial >= div_q) ? trial - div_q : trial;
    rem_d = step[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[6:0], 1'b0};
    end
  end

  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ----- rtl/mmc3_chr_ram_bank_mapper.sv -----
// Bank mapper with a scanline interrupt counter. Each item on in_i gives exactly one result
// on out_o, in order. Register writes and ticks take effect when the item is accepted. A
// lookup whose page is a selector reduced by a configured page count runs through a
// bit-serial remainder unit, retiring one dividend bit a cycle, in ST_CALC and then goes to
// ST_FINISH; every other item goes from acceptance straight to ST_FINISH. There the result
// enters the output register once that is free. The block holds one item at a time and is
// ready again once that result has entered the output register, even while it still waits
// to be taken. Configuration writes on cfg_i are always taken.
module mmc3_chr_ram_bank_mapper (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmc3_item_if.sink  in_i,
  mmc3_result_if.source out_o,
  mmc3_cfg_if.sink   cfg_i
);
  import mmc3_pkg::*;

  // Configuration.
  logic [8:0] prg_count_q, chr_count_q;
  logic       four_screen_q;

  // Mapper state.
  logic [7:0] bank_sel_q;
  logic [7:0] prg_sel_q [2];
  logic [7:0] chr_sel_q [6];
  logic       irq_en_q;
  logic [7:0] irq_cnt_q, irq_rel_q;
  logic       mirror_q;

  // Sequencer and result.
  state_e     state_q, state_d;
  logic [7:0] page_q;
  logic       ram_q, irq_q;
  result_t    res_q;
  logic       out_valid_q;

  logic        in_ready, in_acc, load_out, take_rem;
  item_t       item;
  op_e         op;
  logic [15:0] reg_addr;
  logic [2:0]  target;
  logic        tick_live, irq_hit;

  // Lookup datapath.
  logic [8:0]  last_page, second_page;
  logic [1:0]  prg_win;
  logic [2:0]  chr_win, chr_idx;
  logic [7:0]  chr_sel;
  logic        need_div;
  logic [7:0]  dividend, direct_page;
  logic [8:0]  divisor;
  logic        direct_ram;

  logic [7:0]  rem_value;
  rem_status_t rem_status;

  assign item     = in_i.payload;
  assign op       = op_e'(item.opcode);
  assign reg_addr = item.address & REG_MASK;
  assign target   = bank_sel_q[2:0];
  assign in_acc   = in_i.valid && in_ready;

  assign tick_live = (item.scanline <= LAST_VISIBLE_LINE) && item.rendering_on && irq_en_q;
  assign irq_hit   = tick_live && (irq_cnt_q == 8'd0);

  always_comb begin
    last_page   = (prg_count_q > 9'd0) ? prg_count_q - 9'd1 : 9'd0;
    second_page = (prg_count_q > 9'd1) ? prg_count_q - 9'd2 : 9'd0;
    prg_win     = item.address[14:13];
    chr_win     = item.address[12:10] ^ {bank_sel_q[7], 2'b00};
    // With bank_sel_q[7] clear the lower 4K uses two-page pairs, the upper 4K single selectors; set swaps them.
    chr_idx     = chr_win[2] ? 3'(chr_win[1:0]) + 3'd2 : {2'b00, chr_win[1]};
    chr_sel     = chr_sel_q[chr_idx] + {7'd0, !chr_win[2] && chr_win[0]};

    need_div    = 1'b0;
    dividend    = prg_sel_q[0];
    divisor     = prg_count_q;
    direct_page = 8'd0;
    direct_ram  = 1'b0;
    case (op)
      OP_PRG: begin
        case (prg_win)
          2'd1: begin
            dividend = prg_sel_q[1];
            need_div = 1'b1;
          end
          2'd3: direct_page = last_page[7:0];
          2'd0: begin
            if (bank_sel_q[6]) direct_page = second_page[7:0];
            else need_div = 1'b1;
          end
          default: begin
            if (bank_sel_q[6]) need_div = 1'b1;
            else direct_page = second_page[7:0];
          end
        endcase
        // A zero count reduces every selector to page 0.
        if (prg_count_q == 9'd0) need_div = 1'b0;
      end
      OP_CHR: begin
        dividend = chr_sel;
        divisor  = chr_count_q;
        if (chr_sel[6]) begin
          direct_ram  = 1'b1;
          direct_page = {5'd0, chr_sel[2:0]};
        end else if (chr_count_q != 9'd0) begin
          need_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  mmc3_rem_unit u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && need_div),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .remainder_o (rem_value),
    .status_o    (rem_status)
  );

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = need_div ? ST_CALC : ST_FINISH;
      end
      ST_CALC: begin
        if (rem_status.done && !rem_status.busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    take_rem = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_CALC:   take_rem = rem_status.done && !rem_status.busy;
      ST_FINISH: load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= direct_page;
      ram_q  <= direct_ram;
      irq_q  <= (op == OP_TICK) && irq_hit;
    end else if (take_rem) begin
      page_q <= rem_value;
    end
    if (load_out) begin
      res_q.page_number   <= page_q;
      res_q.page_is_ram   <= ram_q;
      res_q.irq_request   <= irq_q;
      res_q.mirror_select <= mirror_q;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= PRG_COUNT_RESET;
      chr_count_q   <= CHR_COUNT_RESET;
      four_screen_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.payload.index))
        CFG_PRG_COUNT:   prg_count_q   <= cfg_i.payload.value;
        CFG_CHR_COUNT:   chr_count_q   <= cfg_i.payload.value;
        CFG_FOUR_SCREEN: four_screen_q <= cfg_i.payload.value[0];
        default: ;
      endcase
    end
  end

  // Register writes and scanline ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q   <= 8'd0;
      prg_sel_q[0] <= 8'd0;
      prg_sel_q[1] <= 8'd1;
      chr_sel_q[0] <= 8'd0;
      chr_sel_q[1] <= 8'd2;
      chr_sel_q[2] <= 8'd4;
      chr_sel_q[3] <= 8'd5;
      chr_sel_q[4] <= 8'd6;
      chr_sel_q[5] <= 8'd7;
      irq_en_q     <= 1'b0;
      irq_cnt_q    <= 8'd0;
      irq_rel_q    <= 8'd0;
      mirror_q     <= 1'b0;
    end else if (in_acc && op == OP_WRITE) begin
      case (reg_addr)
        REG_BANK_SEL: bank_sel_q <= item.data;
        REG_BANK_DAT: begin
          if (target[2:1] == 2'b11) begin
            prg_sel_q[target[0]] <= item.data;
          end else if (chr_count_q != 9'd0) begin
            // The two-page pairs always start on an even page.
            chr_sel_q[target] <= (target < 3'd2) ? {item.data[7:1], 1'b0} : item.data;
          end
        end
        REG_MIRROR: begin
          if (!four_screen_q) mirror_q <= !item.data[0];
        end
        REG_IRQ_CNT: irq_cnt_q <= item.data;
        REG_IRQ_LAT: irq_rel_q <= item.data;
        REG_IRQ_DIS: begin
          irq_en_q  <= 1'b0;
          irq_cnt_q <= irq_rel_q;
        end
        REG_IRQ_EN: irq_en_q <= 1'b1;
        default: ;
      endcase
    end else if (in_acc && op == OP_TICK && tick_live) begin
      irq_cnt_q <= irq_hit ? irq_rel_q : irq_cnt_q - 8'd1;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;
  assign cfg_i.ready   = 1'b1;

endmodule

// ----- rtl/mmc3_chk.sv -----
`include "mmc3_chr_ram_bank_mapper_defines.svh"

module mmc3_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] page_number_i,
  input logic       page_is_ram_i,
  input logic       irq_request_i,
  input logic       mirror_select_i
);

  // A beat that is not taken stays put.
  `MMC3_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(page_number_i) && $stable(page_is_ram_i) && $stable(irq_request_i) && $stable(mirror_select_i), "stalled result beat changed")

  // Only one item is in work: the input closes after each accepted beat.
  `MMC3_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "second item taken while busy")

  // A tick result never carries a page.
  `MMC3_ASSERT_NOW(a_irq_no_page, out_valid_i && irq_request_i, page_number_i == 8'd0 && !page_is_ram_i, "interrupt result with a page")

  // Character RAM holds eight pages only.
  `MMC3_ASSERT_NOW(a_ram_range, out_valid_i && page_is_ram_i, page_number_i[7:3] == 5'd0, "character RAM page out of range")

endmodule

bind mmc3_chr_ram_bank_mapper mmc3_chk u_mmc3_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .page_number_i   (out_o.payload.page_number),
  .page_is_ram_i   (out_o.payload.page_is_ram),
  .irq_request_i   (out_o.payload.irq_request),
  .mirror_select_i (out_o.payload.mirror_select)
);
